// ----- src/whs_pkg.sv -----
// Package for the wrapped bilinear height sampler: widths, command codes, register map.
// No dependencies.
package whs_pkg;

  localparam int GridBitsDef = 10;
  localparam int FracBitsDef = 8;
  localparam int PosW        = 24;
  localparam int PosFrac     = 8;
  localparam int LaneW       = 16;
  localparam int EntryW      = 64;
  localparam int IndexW      = 20;
  localparam int DepthW      = 25;
  localparam int ShiftW      = 3;
  localparam int PaddrW      = 1;
  localparam logic [ShiftW-1:0] ShiftReset = 3'd2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [PaddrW-1:0] {
    REG_SCALE_SHIFT = 1'b0
  } reg_e;

endpackage

// ----- src/whs_if.sv -----
// Handshake channel interfaces for the height sampler: request and response.
// Depends on whs_pkg.
interface whs_req_if;
  import whs_pkg::*;
  logic                     valid;
  logic                     ready;
  cmd_e                     cmd;
  logic [IndexW-1:0]        entry_index;
  logic signed [LaneW-1:0]  entry_height;
  logic signed [LaneW-1:0]  entry_norm_x;
  logic signed [LaneW-1:0]  entry_norm_y;
  logic signed [LaneW-1:0]  entry_norm_z;
  logic signed [PosW-1:0]   pos_x;
  logic signed [PosW-1:0]   pos_y;
  logic signed [PosW-1:0]   pos_z;
  modport source (output valid, cmd, entry_index, entry_height, entry_norm_x,
                  entry_norm_y, entry_norm_z, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, cmd, entry_index, entry_height, entry_norm_x,
                entry_norm_y, entry_norm_z, pos_x, pos_y, pos_z, output ready);
endinterface

interface whs_rsp_if;
  import whs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DepthW-1:0] depth;
  logic signed [LaneW-1:0]  norm_out_x;
  logic signed [LaneW-1:0]  norm_out_y;
  logic signed [LaneW-1:0]  norm_out_z;
  modport source (output valid, depth, norm_out_x, norm_out_y, norm_out_z, input ready);
  modport sink (input valid, depth, norm_out_x, norm_out_y, norm_out_z, output ready);
endinterface

// ----- src/wrapped_bilinear_height_sampler_unit.sv -----
// Top level of the wrapped bilinear height sampler: address split, four banked
// reads, two-pass lerp pipeline, output registers.  Depends on whs_pkg, whs_if, whs_ram.
//
//  channel  | dir | handshake        | payload
//  req      | in  | valid/ready      | cmd, entry_*, pos_x/y/z
//  rsp      | out | valid/ready      | depth, norm_out_x/y/z
//  apb      | in  | psel/penable     | scale_shift at address 0
//
// One beat enters per cycle while the output is not stalled; a query passes
// through address split with RAM read, horizontal multiply, horizontal sum,
// vertical multiply, vertical sum and round. The four banks, chosen by the parity of
// row and column, each give one read per cycle while the pipeline advances. Reset
// clears valid bits and sets scale_shift to 2; grid contents are undefined until
// written. An output stall freezes the whole pipeline; ready drops only while frozen.
module wrapped_bilinear_height_sampler_unit #(
  parameter int GridBits = whs_pkg::GridBitsDef,
  parameter int FracBits = whs_pkg::FracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  whs_req_if.sink                   req,
  whs_rsp_if.source                 rsp,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [whs_pkg::PaddrW+1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import whs_pkg::*;

  localparam int HalfW  = GridBits - 1;         // bank address bits per axis
  localparam int BankAw = 2 * HalfW;
  localparam int WOne   = 1 << FracBits;
  localparam int WtW    = FracBits + 1;         // weight width, holds W
  localparam int P1W    = LaneW + WtW + 1;      // signed product
  localparam int S1W    = P1W + 1;
  localparam int P2W    = S1W + WtW + 1;
  localparam int S2W    = P2W + 1;
  localparam int ExtW   = PosW + 1 + 7 + GridBits;
  localparam int NStg   = 5;

  // Configuration register.
  logic [ShiftW-1:0] shift_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= ShiftReset;
    end else if (psel && penable && pwrite &&
                 reg_e'(paddr[PaddrW+1:2]) == REG_SCALE_SHIFT) begin
      shift_q <= pwdata[ShiftW-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (reg_e'(paddr[PaddrW+1:2]) == REG_SCALE_SHIFT) begin
      prdata[ShiftW-1:0] = shift_q;
    end
  end

  // Pipeline advance: all stages move together unless the output is held.
  logic adv;
  logic [NStg-1:0] vld_q;
  assign adv = !vld_q[NStg-1] || rsp.ready;
  assign req.ready = adv;
  logic in_fire;
  assign in_fire = req.valid && adv;

  // Stage 0: split coordinates into cell and fraction.
  function automatic logic [GridBits+FracBits-1:0] split_fn(
    input logic signed [PosW-1:0] p, input logic [ShiftW-1:0] sh);
    logic signed [ExtW-1:0] ux;
    logic [ExtW-1:0] sr;
    logic [GridBits+FracBits-1:0] r;
    ux = ExtW'(p) <<< (7 - sh);              // now 15 fraction bits
    ux = ux + (ExtW'(1) <<< (GridBits - 1 + PosFrac + 7));
    sr = ExtW'(ux) >> (PosFrac + 7 - FracBits);
    r = sr[GridBits+FracBits-1:0];
    return r;
  endfunction

  logic [GridBits+FracBits-1:0] cx, cy;
  logic [GridBits-1:0] x0, y0, x1, y1;
  assign cx = split_fn(req.pos_x, shift_q);
  assign cy = split_fn(req.pos_y, shift_q);
  assign x0 = cx[GridBits+FracBits-1:FracBits];
  assign y0 = cy[GridBits+FracBits-1:FracBits];
  assign x1 = x0 + 1'b1;
  assign y1 = y0 + 1'b1;

  // Banks are chosen by row parity and column parity.
  logic [BankAw-1:0] rd_addr [4];
  logic [3:0][EntryW-1:0] rd_data;
  logic [GridBits-1:0] xe, xo, ye, yo;
  assign xe = x0[0] ? x1 : x0;
  assign xo = x0[0] ? x0 : x1;
  assign ye = y0[0] ? y1 : y0;
  assign yo = y0[0] ? y0 : y1;
  assign rd_addr[0] = {ye[GridBits-1:1], xe[GridBits-1:1]};
  assign rd_addr[1] = {ye[GridBits-1:1], xo[GridBits-1:1]};
  assign rd_addr[2] = {yo[GridBits-1:1], xe[GridBits-1:1]};
  assign rd_addr[3] = {yo[GridBits-1:1], xo[GridBits-1:1]};

  logic [2*GridBits-1:0] widx;
  logic [1:0] wbank;
  logic we;
  assign widx  = req.entry_index[2*GridBits-1:0];
  assign wbank = {widx[GridBits], widx[0]};
  assign we    = in_fire && req.cmd == CMD_WRITE;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    whs_ram #(.Width(EntryW), .Depth(1 << BankAw)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we && wbank == 2'(b)),
      .waddr_i({widx[2*GridBits-1:GridBits+1], widx[GridBits-1:1]}),
      .wdata_i({req.entry_norm_z, req.entry_norm_y, req.entry_norm_x, req.entry_height}),
      .re_i   (adv),
      .raddr_i(rd_addr[b]),
      .rdata_o(rd_data[b])
    );
  end

  // Stage 1 side data: fractions, parity swaps, z.
  logic [FracBits-1:0] u1_q, v1_q;
  logic sx1_q, sy1_q;
  logic signed [PosW-1:0] z_q [NStg-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], req.valid && req.cmd == CMD_QUERY};
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      u1_q  <= cx[FracBits-1:0];
      v1_q  <= cy[FracBits-1:0];
      sx1_q <= x0[0];
      sy1_q <= y0[0];
      z_q[0] <= req.pos_z;
      for (int i = 1; i < NStg - 1; i++) begin
        z_q[i] <= z_q[i-1];
      end
    end
  end

  // Corners in order c00, c10, c01, c11 after undoing the bank swap.
  logic [EntryW-1:0] c [4];
  assign c[0] = rd_data[{sy1_q, sx1_q}];
  assign c[1] = rd_data[{sy1_q, !sx1_q}];
  assign c[2] = rd_data[{!sy1_q, sx1_q}];
  assign c[3] = rd_data[{!sy1_q, !sx1_q}];

  logic signed [WtW:0] wu, wnu;
  assign wu  = $signed({2'b00, u1_q});
  assign wnu = $signed((WtW+1)'(WOne) - (WtW+1)'(u1_q));

  // Stage 2: horizontal products.  Stage 3: horizontal sums.
  logic signed [P1W-1:0] pa_q [4][2], pb_q [4][2];
  logic signed [S1W-1:0] sa_q [4], sb_q [4];
  logic [FracBits-1:0] v2_q, v3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        pa_q[k][0] <= P1W'($signed(c[0][16*k +: LaneW]) * wnu);
        pa_q[k][1] <= P1W'($signed(c[1][16*k +: LaneW]) * wu);
        pb_q[k][0] <= P1W'($signed(c[2][16*k +: LaneW]) * wnu);
        pb_q[k][1] <= P1W'($signed(c[3][16*k +: LaneW]) * wu);
        sa_q[k] <= S1W'(pa_q[k][0]) + S1W'(pa_q[k][1]);
        sb_q[k] <= S1W'(pb_q[k][0]) + S1W'(pb_q[k][1]);
      end
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  logic signed [WtW:0] wv, wnv;
  assign wv  = $signed({2'b00, v3_q});
  assign wnv = $signed((WtW+1)'(WOne) - (WtW+1)'(v3_q));

  // Stage 4: vertical products.  Stage 5: sum, round half up, subtract.
  logic signed [P2W-1:0] qa_q [4], qb_q [4];
  logic signed [S2W-1:0] h [4];
  logic signed [LaneW-1:0] res [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      h[k] = S2W'(qa_q[k]) + S2W'(qb_q[k]) + (S2W'(1) <<< (2 * FracBits - 1));
      res[k] = LaneW'(h[k] >>> (2 * FracBits));
    end
  end

  logic signed [DepthW-1:0] depth_q;
  logic signed [LaneW-1:0] nx_q, ny_q, nz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        qa_q[k] <= P2W'(sa_q[k] * wnv);
        qb_q[k] <= P2W'(sb_q[k] * wv);
      end
      depth_q <= DepthW'(z_q[NStg-2]) - DepthW'(res[0]);
      nx_q <= res[1];
      ny_q <= res[2];
      nz_q <= res[3];
    end
  end

  assign rsp.valid      = vld_q[NStg-1];
  assign rsp.depth      = depth_q;
  assign rsp.norm_out_x = nx_q;
  assign rsp.norm_out_y = ny_q;
  assign rsp.norm_out_z = nz_q;

  // A held response stays stable until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.depth))
    else $error("response changed while stalled");
  // Input is refused only while output is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req.ready |-> rsp.valid && !rsp.ready)
    else $error("input stalled without output backpressure");
  // A query beat taken shows up as a valid bit one stage later.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready && req.cmd == CMD_QUERY |=> vld_q[0])
    else $error("query lost at entry");

endmodule

// ----- src/whs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module whs_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Testbench for wrapped_bilinear_height_sampler_unit: directed and random write/query beats,
// scale_shift phases over APB, and a scoreboard that predicts each query result.
// Depends on whs_pkg, whs_if and the RTL of the unit.
`timescale 1ns / 100ps

module testbench;
  import whs_pkg::*;

  localparam int GridN      = 1 << GridBitsDef;
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int DrainWait  = 12;

  typedef struct {
    cmd_e                    cmd;
    logic [IndexW-1:0]       idx;
    logic signed [LaneW-1:0] h, nx, ny, nz;
    logic signed [PosW-1:0]  px, py, pz;
  } beat_t;

  typedef struct {
    logic signed [DepthW-1:0] depth;
    logic signed [LaneW-1:0]  nx, ny, nz;
  } sample_t;

  // Scoreboard: mirrors the grid and scale_shift, and holds the expected samples in order.
  class height_scoreboard;
    logic [EntryW-1:0] grid [int];
    logic [ShiftW-1:0] shift = ShiftReset;
    sample_t           pending [$];
    int                errors = 0;

    function logic [EntryW-1:0] fetch(int x, int y);
      int key;
      key = (y << GridBitsDef) | x;
      return grid.exists(key) ? grid[key] : '0;
    endfunction

    // Bilinear lookup of one query at the current shift.
    function sample_t interpolate(beat_t b);
      int                fb, x0, y0, x1, y1, k;
      longint            ux, uy, u, v, a, c, acc;
      longint            res [4];
      logic [EntryW-1:0] e [4];
      sample_t           s;
      fb = PosFrac + shift;
      ux = longint'(b.px) + (longint'(GridN / 2) << fb);
      uy = longint'(b.py) + (longint'(GridN / 2) << fb);
      x0 = int'((ux >>> fb) & (GridN - 1));
      y0 = int'((uy >>> fb) & (GridN - 1));
      u  = (ux & ((longint'(1) << fb) - 1)) >> (fb - FracBitsDef);
      v  = (uy & ((longint'(1) << fb) - 1)) >> (fb - FracBitsDef);
      x1 = (x0 + 1) % GridN;
      y1 = (y0 + 1) % GridN;
      e[0] = fetch(x0, y0);
      e[1] = fetch(x1, y0);
      e[2] = fetch(x0, y1);
      e[3] = fetch(x1, y1);
      for (k = 0; k < 4; k++) begin
        a = longint'(signed'(e[0][16*k +: 16])) * (256 - u)
          + longint'(signed'(e[1][16*k +: 16])) * u;
        c = longint'(signed'(e[2][16*k +: 16])) * (256 - u)
          + longint'(signed'(e[3][16*k +: 16])) * u;
        acc = a * (256 - v) + c * v;
        // Round half up while dropping both fraction weights.
        res[k] = (acc + (longint'(1) << (2 * FracBitsDef - 1))) >>> (2 * FracBitsDef);
      end
      s.depth = DepthW'(longint'(b.pz) - res[0]);
      s.nx = LaneW'(res[1]);
      s.ny = LaneW'(res[2]);
      s.nz = LaneW'(res[3]);
      return s;
    endfunction

    function void note_beat(beat_t b);
      if (b.cmd == CMD_WRITE) begin
        grid[int'(b.idx)] = {b.nz, b.ny, b.nx, b.h};
      end else begin
        pending.push_back(interpolate(b));
      end
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample: depth %0d", got.depth);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display("sample mismatch: exp depth %0d n %0d %0d %0d, got depth %0d n %0d %0d %0d",
                   want.depth, want.nx, want.ny, want.nz,
                   got.depth, got.nx, got.ny, got.nz);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [PaddrW+1:0] paddr;
  logic [31:0] pwdata, prdata;

  whs_req_if req_ch ();
  whs_rsp_if rsp_ch ();

  wrapped_bilinear_height_sampler_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch.sink),
    .rsp     (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  height_scoreboard board = new();
  bit               stocked [int];
  int               block_x [$];
  int               block_y [$];
  bit               steady = 1'b0;
  bit               hold_request = 1'b0;
  int               stall_count = 0;

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
        if (stall_count >= StallLimit) begin
          $display("** wrapped_bilinear_height_sampler_unit: FAILED **");
          $finish;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    sample_t s;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      s.depth = rsp_ch.depth;
      s.nx = rsp_ch.norm_out_x;
      s.ny = rsp_ch.norm_out_y;
      s.nz = rsp_ch.norm_out_z;
      board.check_result(s);
    end
  end

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  // Sends one beat; entered and left at a falling edge.
  task automatic send_beat(beat_t b);
    if (!steady && $urandom_range(99) < 25) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= b.cmd;
    req_ch.entry_index  <= b.idx;
    req_ch.entry_height <= b.h;
    req_ch.entry_norm_x <= b.nx;
    req_ch.entry_norm_y <= b.ny;
    req_ch.entry_norm_z <= b.nz;
    req_ch.pos_x        <= b.px;
    req_ch.pos_y        <= b.py;
    req_ch.pos_z        <= b.pz;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_beat(b);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_lane();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic put_cell(int x, int y, bit extreme_hi, bit extreme_lo);
    beat_t b;
    b.cmd = CMD_WRITE;
    b.idx = IndexW'((y << GridBitsDef) | x);
    b.h   = extreme_hi ? 16'h7fff : extreme_lo ? 16'h8000 : pick_lane();
    b.nx  = extreme_hi ? 16'h7fff : extreme_lo ? 16'h8000 : pick_lane();
    b.ny  = extreme_hi ? 16'h7fff : extreme_lo ? 16'h8000 : pick_lane();
    b.nz  = extreme_hi ? 16'h7fff : extreme_lo ? 16'h8000 : pick_lane();
    b.px  = PosW'($urandom);
    b.py  = PosW'($urandom);
    b.pz  = PosW'($urandom);
    stocked[int'(b.idx)] = 1'b1;
    send_beat(b);
  endtask

  // Writes any of the four cells of a block that were never written.
  task automatic stock_block(int x0, int y0);
    int i, x, y;
    for (i = 0; i < 4; i++) begin
      x = (x0 + i % 2) % GridN;
      y = (y0 + i / 2) % GridN;
      if (!stocked.exists((y << GridBitsDef) | x)) put_cell(x, y, 1'b0, 1'b0);
    end
  endtask

  function automatic int cell_of(logic signed [PosW-1:0] p);
    int fb;
    fb = PosFrac + board.shift;
    return int'(((longint'(p) + (longint'(GridN / 2) << fb)) >>> fb) & (GridN - 1));
  endfunction

  // Query at an arbitrary position; its neighborhood is stocked first.
  task automatic query_at(logic signed [PosW-1:0] px, logic signed [PosW-1:0] py,
                          logic signed [PosW-1:0] pz);
    beat_t b;
    int    x0, y0;
    x0 = cell_of(px);
    y0 = cell_of(py);
    stock_block(x0, y0);
    block_x.push_back(x0);
    block_y.push_back(y0);
    b.cmd = CMD_QUERY;
    b.idx = IndexW'($urandom);
    b.h   = 16'($urandom);
    b.nx  = 16'($urandom);
    b.ny  = 16'($urandom);
    b.nz  = 16'($urandom);
    b.px  = px;
    b.py  = py;
    b.pz  = pz;
    send_beat(b);
  endtask

  // Position that lands in a given cell with a random fraction and wrap count.
  function automatic logic signed [PosW-1:0] pos_in_cell(int c);
    int     fb;
    longint raw;
    fb  = PosFrac + board.shift;
    raw = ((longint'(c) << fb) | (longint'($urandom) & ((longint'(1) << fb) - 1)))
        - (longint'(GridN / 2) << fb) + (longint'($urandom) << (GridBitsDef + fb));
    return PosW'(raw);
  endfunction

  task automatic set_shift(logic [ShiftW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SCALE_SHIFT, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.shift = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Lets every expected sample come back, then waits out trailing writes.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic random_phase(int n, bit with_hold);
    int i, j;
    for (i = 0; i < n; i++) begin
      steady = (i >= n / 3 && i < n / 3 + 60);
      if (with_hold && i == n / 2) hold_request = 1'b1;
      if ($urandom_range(99) < 10) begin
        put_cell($urandom_range(GridN - 1), $urandom_range(GridN - 1), 1'b0, 1'b0);
      end else if ($urandom_range(99) < 65 && block_x.size() > 0) begin
        j = $urandom_range(block_x.size() - 1);
        query_at(pos_in_cell(block_x[j]), pos_in_cell(block_y[j]), PosW'($urandom));
      end else begin
        query_at(PosW'($urandom), PosW'($urandom), PosW'($urandom));
      end
    end
    steady = 1'b0;
    drain();
  endtask

  initial begin
    logic [ShiftW-1:0] shifts [5] = '{3'd0, 3'd6, 3'd7, 3'd3, 3'd1};
    int p, c;
    req_ch.valid        <= 1'b0;
    req_ch.cmd          <= CMD_WRITE;
    req_ch.entry_index  <= '0;
    req_ch.entry_height <= '0;
    req_ch.entry_norm_x <= '0;
    req_ch.entry_norm_y <= '0;
    req_ch.entry_norm_z <= '0;
    req_ch.pos_x        <= '0;
    req_ch.pos_y        <= '0;
    req_ch.pos_z        <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset shift: full-scale entries, fraction ends, position extremes.
    c = GridN / 2;
    put_cell(c, c, 1'b1, 1'b0);
    put_cell(c + 1, c, 1'b1, 1'b0);
    put_cell(c, c + 1, 1'b1, 1'b0);
    put_cell(c + 1, c + 1, 1'b1, 1'b0);
    query_at(24'sd0, 24'sd0, -24'sd8388608);
    query_at(24'sd1023, 24'sd1023, 24'sd8388607);
    put_cell(c, c, 1'b0, 1'b1);
    put_cell(c + 1, c + 1, 1'b0, 1'b1);
    query_at(24'sd0, 24'sd0, 24'sd8388607);
    query_at(24'sd512, 24'sd511, 24'sd0);
    query_at(-24'sd8388608, -24'sd8388608, -24'sd8388608);
    query_at(24'sd8388607, 24'sd8388607, 24'sd8388607);
    query_at(-24'sd8388608, 24'sd8388607, 24'sd1);
    query_at(-24'sd1, 24'sd1, -24'sd1);
    drain();

    random_phase(220, 1'b1);
    for (p = 0; p < 5; p++) begin
      set_shift(shifts[p]);
      random_phase(p == 1 || p == 2 ? 130 : 110, 1'b0);
    end

    if (board.pending.size() != 0) board.errors += board.pending.size();
    if (board.errors == 0) begin
      $display("** wrapped_bilinear_height_sampler_unit: PASSED **");
    end else begin
      $display("** wrapped_bilinear_height_sampler_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- wrapped_bilinear_height_sampler_unit.f -----
src/whs_pkg.sv
src/whs_if.sv
src/whs_ram.sv
src/wrapped_bilinear_height_sampler_unit.sv
dv/testbench.sv
